/* design/lct_hpc_pkg.sv */
// Package for the LCT header parser and classifier.
// Holds transaction payload types, status and class codes, and register indexes.
// No dependencies.
`default_nettype none

package lct_hpc_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
  localparam logic [3:0]  LCT_VERSION      = 4'd1;
  localparam int unsigned CFG_IDX_W        = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLT_OBJECT_ID   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STSID_OBJECT_ID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MPD_OBJECT_ID   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LLS_CODEPOINT   = 8'd3;

  localparam logic [31:0] RST_SLT_OBJECT_ID   = 32'd1;
  localparam logic [31:0] RST_STSID_OBJECT_ID = 32'd2;
  localparam logic [31:0] RST_MPD_OBJECT_ID   = 32'd3;
  localparam logic [7:0]  RST_LLS_CODEPOINT   = 8'd255;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_NO_PAYLOAD  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SLT   = 2'd1,
    CLS_STSID = 2'd2,
    CLS_MPD   = 2'd3
  } class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    class_e      object_class;
    logic [1:0]  cong_ctrl;
    logic        close_session;
    logic        close_object;
    logic [7:0]  code_point;
    logic [31:0] congestion_info;
    logic [31:0] session_id;
    logic [31:0] object_id;
    logic [15:0] svc_id;
    logic [9:0]  hdr_len;
    logic [15:0] payload_length;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          wdata;
  } cfg_t;

endpackage

`default_nettype wire

/* design/lct_hpc_if.sv */
// Valid/ready channel interfaces for the LCT header parser and classifier.
// Depends on lct_hpc_pkg for the payload types.
`default_nettype none

interface lct_hpc_in_if;
  logic              valid;
  logic              ready;
  lct_hpc_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lct_hpc_out_if;
  logic              valid;
  logic              ready;
  lct_hpc_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lct_hpc_cfg_if;
  logic              valid;
  logic              ready;
  lct_hpc_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/lct_header_parse_and_classify_top.sv */
// LCT header parser and classifier top level.
// Depends on lct_hpc_pkg and the channel interfaces in lct_hpc_if.sv.
//
//   channel | dir | payload                         | transaction when
//   in_i    | in  | data_byte, last_byte            | in_i.valid && in_i.ready
//   out_o   | out | status, class, header fields    | out_o.valid && out_o.ready
//   cfg_i   | in  | reg_index, wdata                | cfg_i.valid (ready tied high)
//
// One byte per cycle unless stalled; each byte updates the working header registers.
// The last byte copies the parsed header into a snapshot register; the result is
// built from it and loads the output register once the output stage can advance.
// A stalled output holds the snapshot; bytes keep flowing until both are full.
// Reset clears the working registers, the valid flags and loads register defaults.
`default_nettype none

module lct_header_parse_and_classify_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  lct_hpc_in_if.sink   in_i,
  lct_hpc_out_if.source out_o,
  lct_hpc_cfg_if.sink  cfg_i
);
  import lct_hpc_pkg::*;

  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  first_byte;
    logic [7:0]  flag_byte;
    logic [7:0]  length_words;
    logic [7:0]  codepoint;
    logic [31:0] cci;
    logic [31:0] tsi;
    logic [31:0] toi;
  } pkt_t;

  typedef struct packed {
    logic [4:0] cci_len;
    logic [4:0] tsi_len;
    logic [4:0] toi_len;
    logic [4:0] toi_cap;
  } layout_t;

  function automatic layout_t get_layout(input logic [7:0] fb, input logic [7:0] flg);
    layout_t l;
    l.cci_len = (fb[3:2] != 2'd0) ? 5'd4 : 5'd0;
    l.tsi_len = flg[7] ? (flg[4] ? 5'd2 : 5'd4) : 5'd0;
    unique case (flg[6:5])
      2'd0:    l.toi_len = 5'd0;
      2'd1:    l.toi_len = flg[4] ? 5'd2 : 5'd4;
      2'd2:    l.toi_len = flg[4] ? 5'd4 : 5'd8;
      default: l.toi_len = flg[4] ? 5'd6 : 5'd12;
    endcase
    l.toi_cap = (flg[6:5] == 2'd0) ? 5'd0 : ((flg[6:5] == 2'd1 && flg[4]) ? 5'd2 : 5'd4);
    return l;
  endfunction

  logic [31:0] slt_id_q, stsid_id_q, mpd_id_q;
  logic [7:0]  lls_cp_q;

  pkt_t    work_q, work_d, snap_q;
  logic    snap_valid_q, out_valid_q;
  out_t    out_q, res;
  layout_t lay_w, lay_s;
  logic [4:0]  ts, os, oe, min_hdr;
  logic [9:0]  hb_w, hb;
  logic [15:0] idx;
  logic        in_acc, s2_adv, s1_adv;

  assign s2_adv = !out_valid_q || out_o.ready;
  assign s1_adv = snap_valid_q && s2_adv;
  assign in_i.ready = !snap_valid_q || s2_adv;
  assign in_acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Per-byte header capture
  always_comb begin
    idx    = work_q.len;
    lay_w  = get_layout(work_q.first_byte, work_q.flag_byte);
    ts     = 5'd4 + lay_w.cci_len;
    os     = ts + lay_w.tsi_len;
    oe     = os + lay_w.toi_cap;
    work_d = work_q;
    priority if (idx == 16'd0) begin
      work_d.first_byte = in_i.data.data_byte;
    end else if (idx == 16'd1) begin
      work_d.flag_byte = in_i.data.data_byte;
    end else if (idx == 16'd2) begin
      work_d.length_words = in_i.data.data_byte;
    end else if (idx == 16'd3) begin
      work_d.codepoint = in_i.data.data_byte;
    end else if (idx < {11'd0, ts}) begin
      work_d.cci = {work_q.cci[23:0], in_i.data.data_byte};
    end else if (idx < {11'd0, os}) begin
      work_d.tsi = {work_q.tsi[23:0], in_i.data.data_byte};
    end else if (idx < {11'd0, oe}) begin
      work_d.toi = {work_q.toi[23:0], in_i.data.data_byte};
    end else begin
      work_d.toi = work_q.toi;
    end
    work_d.len = (idx >= MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : idx + 16'd1;
  end

  // Result from the snapshot
  always_comb begin
    lay_s   = get_layout(snap_q.first_byte, snap_q.flag_byte);
    min_hdr = 5'd4 + lay_s.cci_len + lay_s.tsi_len + lay_s.toi_len;
    hb_w    = {snap_q.length_words, 2'b00};
    hb      = (hb_w < {5'd0, min_hdr}) ? {5'd0, min_hdr} : hb_w;
    res     = '0;
    priority if (snap_q.len < 16'd4) begin
      res.status = ST_SHORT;
    end else if (snap_q.first_byte[7:4] != LCT_VERSION) begin
      res.status = ST_BAD_VERSION;
    end else if (snap_q.len < {11'd0, min_hdr}) begin
      res.status = ST_TRUNCATED;
    end else begin
      res.cong_ctrl          = snap_q.first_byte[3:2];
      res.close_session      = snap_q.flag_byte[1];
      res.close_object       = snap_q.flag_byte[0];
      res.code_point         = snap_q.codepoint;
      res.congestion_info    = snap_q.cci;
      res.session_id         = snap_q.tsi;
      res.object_id          = snap_q.toi;
      res.svc_id             = snap_q.tsi[15:0];
      res.hdr_len            = hb;
      if ({6'd0, hb} >= snap_q.len) begin
        res.status = ST_NO_PAYLOAD;
      end else begin
        res.status = ST_OK;
        priority if (snap_q.toi == slt_id_q || snap_q.codepoint == lls_cp_q) begin
          res.object_class = CLS_SLT;
        end else if (snap_q.toi == stsid_id_q) begin
          res.object_class = CLS_STSID;
        end else if (snap_q.toi == mpd_id_q) begin
          res.object_class = CLS_MPD;
        end else begin
          res.object_class = CLS_NONE;
        end
        res.payload_length = snap_q.len - {6'd0, hb};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slt_id_q   <= RST_SLT_OBJECT_ID;
      stsid_id_q <= RST_STSID_OBJECT_ID;
      mpd_id_q   <= RST_MPD_OBJECT_ID;
      lls_cp_q   <= RST_LLS_CODEPOINT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        CFG_SLT_OBJECT_ID:   slt_id_q   <= cfg_i.data.wdata;
        CFG_STSID_OBJECT_ID: stsid_id_q <= cfg_i.data.wdata;
        CFG_MPD_OBJECT_ID:   mpd_id_q   <= cfg_i.data.wdata;
        CFG_LLS_CODEPOINT:   lls_cp_q   <= cfg_i.data.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q       <= '0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        work_q <= in_i.data.last_byte ? '0 : work_d;
      end
      if (in_acc && in_i.data.last_byte) begin
        snap_valid_q <= 1'b1;
      end else if (s1_adv) begin
        snap_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.last_byte) begin
      snap_q <= work_d;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire
